@@ rtl/lcdfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfb_pkg: shared types and constants for the LCD framebuffer refresh block
// Request codes, decoded command layout, sync bytes and nibble split helpers.
// ----------------------------------------------------------------------------
package lcdfb_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;

    localparam logic [2:0] FUNC_PIXEL   = 3'd0;
    localparam logic [2:0] FUNC_COMMAND = 3'd1;
    localparam logic [2:0] FUNC_DATA    = 3'd2;
    localparam logic [2:0] FUNC_REFRESH = 3'd3;
    localparam logic [2:0] FUNC_CURSOR  = 3'd4;

    localparam logic [7:0] SYNC_CMD  = 8'hF8;
    localparam logic [7:0] SYNC_DATA = 8'hFA;
    localparam logic [7:0] ADDR_BASE = 8'h80;

    localparam logic [3:0] LEN_SINGLE = 4'd2;
    localparam logic [3:0] LEN_PACKET = 4'd8;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_SINGLE,
        OP_REFRESH
    } op_t;

    // One decoded request as it travels from the front end to the engine.
    typedef struct packed {
        op_t        op;
        logic [7:0] sync;
        logic [7:0] value;
        logic [7:0] word_addr;
        logic [4:0] bit_sel;
        logic       pix_on;
        logic [4:0] row;
    } cmd_t;

    function automatic logic [15:0] split_byte(input logic [7:0] b);
        return {b[7:4], 4'h0, b[3:0], 4'h0};
    endfunction

    function automatic logic [63:0] single_payload(input logic [7:0] b);
        return {split_byte(b), 48'h0};
    endfunction

    // The most significant byte of a stored word is the first byte on the screen.
    function automatic logic [63:0] packet_payload(input logic [31:0] w);
        return {split_byte(w[31:24]), split_byte(w[23:16]),
                split_byte(w[15:8]), split_byte(w[7:0])};
    endfunction

endpackage

@@ rtl/lcdfb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfb_front: request decoder
// Accepts request words, drops those that have no effect, and turns the rest
// into decoded commands for the queue.
// ----------------------------------------------------------------------------
module lcdfb_front
    import lcdfb_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    input  logic       pixel_on,
    input  logic [7:0] byte_value,
    input  logic [4:0] gdram_row,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_data
);

    logic       keep;
    logic       in_range;
    logic [7:0] cursor_base;

    assign in_ready = !q_full;

    assign in_range = ({1'b0, pos_x} < 9'(SCREEN_WIDTH)) &&
                      ({1'b0, pos_y} < 9'(SCREEN_HEIGHT));

    assign cursor_base = ADDR_BASE | {3'b000, pos_y[0], pos_y[1], 3'b000};

    always_comb
    begin
        q_data           = '0;
        q_data.op        = OP_SINGLE;
        keep             = 1'b0;
        // Word address is line * 4 + x / 32; the bit within the word counts
        // down from the most significant end.
        q_data.word_addr = {pos_y[5:0], pos_x[6:5]};
        q_data.bit_sel   = ~pos_x[4:0];
        q_data.pix_on    = pixel_on;
        q_data.row       = gdram_row;
        case (func)
            FUNC_PIXEL:
            begin
                q_data.op = OP_PIXEL;
                keep      = in_range;
            end
            FUNC_COMMAND:
            begin
                q_data.sync  = SYNC_CMD;
                q_data.value = byte_value;
                keep         = 1'b1;
            end
            FUNC_DATA:
            begin
                q_data.sync  = SYNC_DATA;
                q_data.value = byte_value;
                keep         = 1'b1;
            end
            FUNC_REFRESH:
            begin
                q_data.op = OP_REFRESH;
                keep      = 1'b1;
            end
            FUNC_CURSOR:
            begin
                q_data.sync  = SYNC_CMD;
                q_data.value = cursor_base + pos_x;
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = in_valid && in_ready && keep;

endmodule

@@ rtl/lcdfb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfb_queue: command queue
// Small FIFO of decoded commands between the decoder and the frame engine.
// ----------------------------------------------------------------------------
module lcdfb_queue
    import lcdfb_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("command queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("command queue count out of range");

endmodule

@@ rtl/lcdfb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfb_back: frame engine and framebuffer
// Executes queued commands: read-modify-write of pixel bits, and emission of
// command, data and refresh packet frames into the output register.
// ----------------------------------------------------------------------------
module lcdfb_back
    import lcdfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  sync_byte,
    output logic [63:0] payload,
    output logic [3:0]  payload_len,
    output logic        last_frame
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PIX_RD,
        S_PIX_WR,
        S_SINGLE,
        S_ROWCMD,
        S_COLCMD,
        S_PKT_RD,
        S_PKT_EMIT
    } state_t;

    localparam logic [2:0] LAST_PKT = 3'd7;

    state_t       state_reg;
    cmd_t         cur_reg;
    logic [2:0]   pkt_cnt_reg;
    logic         out_valid_reg;
    logic [7:0]   sync_reg;
    logic [63:0]  payload_reg;
    logic [3:0]   len_reg;
    logic         last_reg;
    logic [255:0] word_valid_reg;

    // Framebuffer: 256 words of 32 bits, one quarter of a pixel line each.
    logic [31:0]  mem [256];
    logic [31:0]  rdata_reg;
    logic         rvalid_reg;

    logic         rd_en;
    logic [7:0]   rd_addr;
    logic         wr_en;
    logic [31:0]  word_now;
    logic [31:0]  bit_mask;
    logic [31:0]  wr_data;
    logic         out_free;
    logic         out_load;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_free = !out_valid_reg || out_ready;

    // The engine loads a new frame into the output register this cycle.
    assign out_load = out_free && ((state_reg == S_SINGLE) || (state_reg == S_ROWCMD) ||
                                   (state_reg == S_COLCMD) || (state_reg == S_PKT_EMIT));

    assign rd_en   = (state_reg == S_PIX_RD) || (state_reg == S_PKT_RD);
    // Packets walk line row first, then line row + 32, four words per line.
    assign rd_addr = (state_reg == S_PKT_RD) ?
                     {pkt_cnt_reg[2], cur_reg.row, pkt_cnt_reg[1:0]} : cur_reg.word_addr;

    // A word that was never written reads as zero.
    assign word_now = rvalid_reg ? rdata_reg : '0;
    assign bit_mask = 32'h1 << cur_reg.bit_sel;
    assign wr_data  = cur_reg.pix_on ? (word_now | bit_mask) : (word_now & ~bit_mask);
    assign wr_en    = (state_reg == S_PIX_WR);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_reg.word_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg  <= mem[rd_addr];
            rvalid_reg <= word_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            pkt_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            sync_reg       <= '0;
            payload_reg    <= '0;
            len_reg        <= '0;
            last_reg       <= 1'b0;
            word_valid_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg     <= q_head;
                        pkt_cnt_reg <= '0;
                        case (q_head.op)
                            OP_PIXEL:   state_reg <= S_PIX_RD;
                            OP_SINGLE:  state_reg <= S_SINGLE;
                            OP_REFRESH: state_reg <= S_ROWCMD;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_PIX_RD:
                begin
                    state_reg <= S_PIX_WR;
                end
                S_PIX_WR:
                begin
                    word_valid_reg[cur_reg.word_addr] <= 1'b1;
                    state_reg                         <= S_IDLE;
                end
                S_SINGLE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sync_reg      <= cur_reg.sync;
                        payload_reg   <= single_payload(cur_reg.value);
                        len_reg       <= LEN_SINGLE;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_ROWCMD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sync_reg      <= SYNC_CMD;
                        payload_reg   <= single_payload(ADDR_BASE + {3'b000, cur_reg.row});
                        len_reg       <= LEN_SINGLE;
                        last_reg      <= 1'b0;
                        state_reg     <= S_COLCMD;
                    end
                end
                S_COLCMD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sync_reg      <= SYNC_CMD;
                        payload_reg   <= single_payload(ADDR_BASE);
                        len_reg       <= LEN_SINGLE;
                        last_reg      <= 1'b0;
                        state_reg     <= S_PKT_RD;
                    end
                end
                S_PKT_RD:
                begin
                    state_reg <= S_PKT_EMIT;
                end
                S_PKT_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sync_reg      <= SYNC_DATA;
                        payload_reg   <= packet_payload(word_now);
                        len_reg       <= LEN_PACKET;
                        last_reg      <= (pkt_cnt_reg == LAST_PKT);
                        if (pkt_cnt_reg == LAST_PKT)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pkt_cnt_reg <= pkt_cnt_reg + 1'b1;
                            state_reg   <= S_PKT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign sync_byte   = sync_reg;
    assign payload     = payload_reg;
    assign payload_len = len_reg;
    assign last_frame  = last_reg;

    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (len_reg == LEN_SINGLE || len_reg == LEN_PACKET))
        else $error("frame length is neither single nor packet");

    a_packet_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && len_reg == LEN_PACKET) |-> (sync_reg == SYNC_DATA))
        else $error("refresh packet without data sync");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ($past(state_reg) == S_PIX_RD))
        else $error("framebuffer written without a preceding read");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != S_IDLE))
        else $error("engine stayed idle after taking a command");

endmodule

@@ rtl/serial_lcd_framebuffer_refresh.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_lcd_framebuffer_refresh: 128x64 monochrome LCD framebuffer and
// serial frame generator
// Request decoder, command queue and frame engine with a 1 KiB framebuffer.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Word
//  -------  -------------------  ---------------------------------------------
//  in       in_valid / in_ready  func, pos_x, pos_y, pixel_on, byte_value,
//                                gdram_row
//  out      out_valid/out_ready  sync_byte, payload, payload_len, last_frame
//
// A pixel write passes through queue pop, framebuffer read and write.
// A command, data or cursor word is loaded into the output register once that is free.
// A row refresh emits two command frames, then eight packets that
// each need one framebuffer read and one output load.
// After reset every framebuffer word reads as zero through per-word valid
// bits, so there is no clearing pass. The queue lets requests enter while the
// engine waits on a stalled output; in_ready drops only when the queue is full.
//
module serial_lcd_framebuffer_refresh
    import lcdfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic        pixel_on,
    input  logic [7:0]  byte_value,
    input  logic [4:0]  gdram_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  sync_byte,
    output logic [63:0] payload,
    output logic [3:0]  payload_len,
    output logic        last_frame
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t q_in;
    cmd_t q_head;

    lcdfb_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pixel_on   (pixel_on),
        .byte_value (byte_value),
        .gdram_row  (gdram_row),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    lcdfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    lcdfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sync_byte   (sync_byte),
        .payload     (payload),
        .payload_len (payload_len),
        .last_frame  (last_frame)
    );

endmodule
